@@ hdl/lttt_pkg.sv @@
// Shared constants and types for the linear-to-tiled texture reorder.
// No dependencies; used by all hdl/ files.
`timescale 1ns / 1ps

package lttt_pkg;

  // Line buffer geometry
  localparam int DEF_MAX_ROW_WORDS = 256;
  localparam int BAND_ROWS         = 4;
  localparam logic [1:0] LAST_ROW  = 2'd3;
  localparam int MAX_BANDS         = 256;

  // Data widths
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_W      = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Register reset values
  localparam logic             RST_TEXEL_MODE   = 1'b0;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

  // Output queue: a tail word is taken only if a whole run of four fits
  // on top of the one word that may still be queued from the prior run.
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_ROOM  = OFIFO_DEPTH - BAND_ROWS - 1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              run_end;
    logic              image_end;
  } out_item_t;

endpackage

@@ hdl/linear_to_tiled_texture_unit.sv @@
// Linear-to-tiled texture reorder: line buffer of three rows, read sequencer.
// Depends on lttt_pkg and lttt_ofifo.
// Rows 0-2: one word per cycle while the run sequencer is free, no result.
// Row 3: a word waits while the prior run is read (one line-buffer read port
// serves three reads). A run's first result passes rd_data_q, then the queue.
// Reset clears position, queue and registers (mode 0, 640 x 480); the line
// buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module linear_to_tiled_texture_unit #(
  parameter int MAX_ROW_WORDS = lttt_pkg::DEF_MAX_ROW_WORDS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lttt_pkg::WORD_W-1:0]     in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lttt_pkg::WORD_W-1:0]     out_word_o,
  output logic                            run_end_o,
  output logic                            image_end_o,
  input  logic                            cfg_we_i,
  input  logic [lttt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lttt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int ColW   = $clog2(MAX_ROW_WORDS);
  localparam int BufLen = (lttt_pkg::BAND_ROWS - 1) * MAX_ROW_WORDS;
  localparam int AddrW  = $clog2(BufLen);
  localparam int MaxW   = $clog2(MAX_ROW_WORDS + 1);
  localparam int LenW   = ((MaxW > 9) ? MaxW : 9) + 1;
  localparam int QCntW  = $clog2(lttt_pkg::OFIFO_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_RD1   = 5'b00010,
    PH_RD2   = 5'b00100,
    PH_DRAIN = 5'b01000,
    PH_LAST  = 5'b10000
  } ph_e;

  // Configuration
  logic                       mode_q;
  logic [lttt_pkg::DIM_W-1:0] width_q;
  logic [lttt_pkg::DIM_W-1:0] height_q;
  logic                       cfg_hit;

  // Position
  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      row_q, row_d;
  logic [7:0]      band_q, band_d;

  // Run sequencer
  ph_e                         ph_q, ph_d;
  logic [ColW-1:0]             rcol_q;
  logic [lttt_pkg::WORD_W-1:0] tail_word_q;
  logic                        tail_iend_q;

  // Line buffer
  logic [lttt_pkg::WORD_W-1:0] buf_mem [BufLen];
  logic [lttt_pkg::WORD_W-1:0] rd_data_q;
  logic [AddrW-1:0]            rd_addr, wr_addr, rd_base, wr_base;
  logic [1:0]                  rd_row;
  logic [ColW-1:0]             rd_col;
  logic                        rd_en, wr_en;

  // Geometry
  logic [8:0]      wpr_raw, bands_raw, bands;
  logic [LenW-1:0] wpr;
  logic            last_col, last_band;

  logic                accept, is_tail, seq_free, room;
  logic                push;
  lttt_pkg::out_item_t push_item, head;
  logic [QCntW-1:0]    q_cnt;

  // ---------------------------------------------------------------- config
  always_comb begin
    case (cfg_idx_i)
      lttt_pkg::REG_TEXEL_MODE,
      lttt_pkg::REG_IMAGE_WIDTH,
      lttt_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we_i;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lttt_pkg::RST_TEXEL_MODE;
      width_q  <= lttt_pkg::RST_IMAGE_WIDTH;
      height_q <= lttt_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lttt_pkg::REG_TEXEL_MODE:   mode_q   <= cfg_wdata_i[0];
        lttt_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        lttt_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- geometry
  assign wpr_raw = mode_q ? {1'b0, width_q[10:3]} : width_q[10:2];
  always_comb begin
    if (wpr_raw == '0) begin
      wpr = LenW'(1);
    end else if (LenW'(wpr_raw) > LenW'(MAX_ROW_WORDS)) begin
      wpr = LenW'(MAX_ROW_WORDS);
    end else begin
      wpr = LenW'(wpr_raw);
    end
  end

  assign bands_raw = height_q[10:2];
  always_comb begin
    if (bands_raw == '0) begin
      bands = 9'd1;
    end else if (bands_raw > 9'(lttt_pkg::MAX_BANDS)) begin
      bands = 9'(lttt_pkg::MAX_BANDS);
    end else begin
      bands = bands_raw;
    end
  end

  assign last_col  = (LenW'(col_q) + LenW'(1)) >= wpr;
  assign last_band = ({1'b0, band_q} + 9'd1) >= bands;

  // ------------------------------------------------------------- handshake
  assign is_tail    = (row_q == lttt_pkg::LAST_ROW);
  assign seq_free   = (ph_q == PH_IDLE) || (ph_q == PH_LAST);
  assign room       = (q_cnt <= QCntW'(lttt_pkg::OFIFO_ROOM));
  assign in_stall_o = !seq_free || (is_tail && !room);
  assign accept     = in_valid_i && !in_stall_o;

  // -------------------------------------------------------------- position
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    band_d = band_q;
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      band_d = '0;
    end else if (accept) begin
      if (!last_col) begin
        col_d = col_q + ColW'(1);
      end else begin
        col_d = '0;
        row_d = row_q + 2'd1;
        if (is_tail) begin
          band_d = last_band ? '0 : band_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      band_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      band_q <= band_d;
    end
  end

  // ------------------------------------------------------------- sequencer
  // A tail word reads row 0 as it is taken, rows 1 and 2 in PH_RD1 and PH_RD2;
  // the registered read data is pushed into the queue in the following cycle.
  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_IDLE:  ph_d = (accept && is_tail) ? PH_RD1 : PH_IDLE;
      PH_RD1:   ph_d = PH_RD2;
      PH_RD2:   ph_d = PH_DRAIN;
      PH_DRAIN: ph_d = PH_LAST;
      PH_LAST:  ph_d = (accept && is_tail) ? PH_RD1 : PH_IDLE;
      default:  ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_tail) begin
      rcol_q      <= col_q;
      tail_word_q <= in_word_i;
      tail_iend_q <= last_col && last_band;
    end
  end

  // ----------------------------------------------------------- line buffer
  always_comb begin
    case (ph_q)
      PH_RD1: begin
        rd_row = 2'd1;
        rd_col = rcol_q;
      end
      PH_RD2: begin
        rd_row = 2'd2;
        rd_col = rcol_q;
      end
      default: begin
        rd_row = 2'd0;
        rd_col = col_q;
      end
    endcase
  end

  always_comb begin
    case (rd_row)
      2'd0:    rd_base = '0;
      2'd1:    rd_base = AddrW'(MAX_ROW_WORDS);
      default: rd_base = AddrW'(2 * MAX_ROW_WORDS);
    endcase
    case (row_q)
      2'd0:    wr_base = '0;
      2'd1:    wr_base = AddrW'(MAX_ROW_WORDS);
      default: wr_base = AddrW'(2 * MAX_ROW_WORDS);
    endcase
  end

  assign rd_addr = rd_base + AddrW'(rd_col);
  assign wr_addr = wr_base + AddrW'(col_q);
  assign rd_en   = (accept && is_tail) || (ph_q == PH_RD1) || (ph_q == PH_RD2);
  assign wr_en   = accept && !is_tail;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= in_word_i;
    end
    if (rd_en) begin
      rd_data_q <= buf_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------- output queue
  always_comb begin
    push                = (ph_q != PH_IDLE);
    push_item.word      = rd_data_q;
    push_item.run_end   = 1'b0;
    push_item.image_end = 1'b0;
    if (ph_q == PH_LAST) begin
      push_item.word      = tail_word_q;
      push_item.run_end   = 1'b1;
      push_item.image_end = tail_iend_q;
    end
  end

  lttt_ofifo #(
    .Depth (lttt_pkg::OFIFO_DEPTH)
  ) u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (out_valid_o && !out_stall_i),
    .head_o      (head),
    .count_o     (q_cnt)
  );

  assign out_valid_o = (q_cnt != '0);
  assign out_word_o  = head.word;
  assign run_end_o   = head.run_end;
  assign image_end_o = head.image_end;

endmodule

@@ hdl/lttt_ofifo.sv @@
// Output word queue for the texture reorder.
// Depends on lttt_pkg (out_item_t, OFIFO_DEPTH).
`timescale 1ns / 1ps

module lttt_ofifo #(
  parameter int Depth = lttt_pkg::OFIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  lttt_pkg::out_item_t        push_data_i,
  input  logic                       pop_i,
  output lttt_pkg::out_item_t        head_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  lttt_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

@@ hdl/lttt_check.sv @@
// Port-level checks for the texture reorder, bound to the top level.
// Depends on lttt_pkg widths.
`timescale 1ns / 1ps

module lttt_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lttt_pkg::WORD_W-1:0] out_word_o,
  input logic                        run_end_o,
  input logic                        image_end_o
);

  logic       out_acc;
  logic [1:0] pos_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // position of the next delivered word within its run of four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_acc) begin
      pos_q <= pos_q + 2'd1;
    end
  end

  a_run_end_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (run_end_o == (pos_q == 2'd3)))
    else $error("run_end not on every fourth word");

  a_iend_on_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_end_o |-> run_end_o)
    else $error("image_end without run_end");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

endmodule

bind linear_to_tiled_texture_unit lttt_check u_lttt_check (.*);

@@ dv/tb_linear_to_tiled_texture_unit.sv @@
// Testbench for linear_to_tiled_texture_unit: linear-order words in, tiled-order words
// out, checked word by word against an in-bench model of the line buffer and position.
// Depends on lttt_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_linear_to_tiled_texture_unit;
  import lttt_pkg::*;

  localparam int ROW_CAP        = DEF_MAX_ROW_WORDS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_WORDS     = 150;
  localparam int SAT_WORDS      = 24;
  localparam int HOLD_PHASE     = 2;
  localparam int PAUSE_PHASE    = 4;
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_TAIL} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [WORD_W-1:0]      word;
    logic [2:0][WORD_W-1:0] held;     // rows 0..2 due ahead of a row-3 word
    logic                   img_end;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [WORD_W-1:0]     in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [WORD_W-1:0]     out_word_o;
  logic                  run_end_o;
  logic                  image_end_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // model state
  logic [WORD_W-1:0] band_mem [0:3*ROW_CAP-1];
  int unsigned       col_pos, row_pos, band_pos;
  logic              mode_q;
  logic [DIM_W-1:0]  width_q, height_q;
  out_item_t         tile_run [0:3];
  int                tile_cnt;

  out_item_t         typed_run [0:3];
  bit                cur_typed = 1'b0;
  out_item_t         tiled_q [$];
  out_item_t         want;
  dir_row_t          dir_tab [$];
  logic [WORD_W-1:0] pat [0:11];

  int errors       = 0;
  int words_in     = 0;
  int words_out    = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;
  bit burst        = 1'b0;
  bit hold_req     = 1'b0;

  linear_to_tiled_texture_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .run_end_o   (run_end_o),
    .image_end_o (image_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned row_words();
    int unsigned n;
    n = mode_q ? (width_q >> 3) : (width_q >> 2);
    if (n == 0) n = 1;
    if (n > ROW_CAP) n = ROW_CAP;
    return n;
  endfunction

  function automatic int unsigned band_count();
    int unsigned n;
    n = height_q >> 2;
    if (n == 0) n = 1;
    if (n > MAX_BANDS) n = MAX_BANDS;
    return n;
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    bit known;
    known = 1'b1;
    case (idx)
      REG_TEXEL_MODE:   mode_q = val[0];
      REG_IMAGE_WIDTH:  width_q = val;
      REG_IMAGE_HEIGHT: height_q = val;
      default:          known = 1'b0;
    endcase
    // any real register write restarts the image; buffer contents stay
    if (known) begin
      col_pos  = 0;
      row_pos  = 0;
      band_pos = 0;
    end
  endtask

  // One linear word in: store rows 0..2, or emit the column of the band on row 3.
  task automatic tile_step(input logic [WORD_W-1:0] w);
    int unsigned col;
    bit          last_col, last_band;
    col       = (col_pos >= ROW_CAP) ? ROW_CAP - 1 : col_pos;
    last_col  = (col + 1 >= row_words());
    last_band = (band_pos + 1 >= band_count());
    tile_cnt  = 0;
    if (row_pos < LAST_ROW) begin
      band_mem[row_pos * ROW_CAP + col] = w;
    end else begin
      for (int r = 0; r < LAST_ROW; r++) begin
        tile_run[r].word      = band_mem[r * ROW_CAP + col];
        tile_run[r].run_end   = 1'b0;
        tile_run[r].image_end = 1'b0;
      end
      tile_run[LAST_ROW].word      = w;
      tile_run[LAST_ROW].run_end   = 1'b1;
      tile_run[LAST_ROW].image_end = last_col && last_band;
      tile_cnt = BAND_ROWS;
    end
    if (!last_col) begin
      col_pos = col + 1;
    end else begin
      col_pos = 0;
      if (row_pos < LAST_ROW) begin
        row_pos++;
      end else begin
        row_pos  = 0;
        band_pos = last_band ? 0 : band_pos + 1;
      end
    end
  endtask

  task automatic report(input string what, input logic [WORD_W-1:0] exp_v,
                        input logic [WORD_W-1:0] got_v);
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_we_i) begin
        apply_reg(cfg_idx_i, cfg_wdata_i);
        cfg_writes++;
        quiet_cycles = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        tile_step(in_word_i);
        words_in++;
        quiet_cycles = 0;
        for (int k = 0; k < tile_cnt; k++)
          tiled_q.push_back(cur_typed ? typed_run[k] : tile_run[k]);
      end
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        quiet_cycles = 0;
        if (tiled_q.size() == 0) begin
          report("unexpected word", '0, out_word_o);
        end else begin
          want = tiled_q.pop_front();
          if (out_word_o !== want.word) report("out_word", want.word, out_word_o);
          if (run_end_o !== want.run_end)
            report("run_end", WORD_W'(want.run_end), WORD_W'(run_end_o));
          if (image_end_o !== want.image_end)
            report("image_end", WORD_W'(want.image_end), WORD_W'(image_end_o));
        end
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[linear_to_tiled_texture_unit] ERROR");
    $finish;
  end

  // output side: random stall before each word unless no_idle, one long hold-off on request
  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    gap = (no_idle || burst) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tiled_q.size() != 0) @(negedge clk_i);
  endtask

  // rows 0..2 give no result, so let the block settle before a write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    dir_tab.push_back(row);
  endtask

  task automatic add_word(input logic [WORD_W-1:0] w);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.word = w;
    dir_tab.push_back(row);
  endtask

  task automatic add_tail(input logic [WORD_W-1:0] h0, h1, h2, w, input logic img_end);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_TAIL;
    row.held[0] = h0;
    row.held[1] = h1;
    row.held[2] = h2;
    row.word    = w;
    row.img_end = img_end;
    dir_tab.push_back(row);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int img;
    int rand_words;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b1;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_TEXEL_MODE;
    cfg_wdata_i = '0;
    mode_q      = RST_TEXEL_MODE;
    width_q     = RST_IMAGE_WIDTH;
    height_q    = RST_IMAGE_HEIGHT;
    col_pos     = 0;
    row_pos     = 0;
    band_pos    = 0;
    phase       = 0;
    rand_words  = 0;
    foreach (pat[k]) pat[k] = {$urandom, $urandom};

    // reset defaults: 160 words per row, row 0 yields nothing
    add_word('0);
    add_word(ALL_ONES);
    // 8 bpp, 16 wide, 4 high: two words per row, one band
    add_reg(REG_TEXEL_MODE, 11'd1);
    add_reg(REG_IMAGE_WIDTH, 11'd16);
    add_reg(REG_IMAGE_HEIGHT, 11'd4);
    add_word(pat[0]);
    add_word(pat[1]);
    add_word(pat[2]);
    add_reg(REG_SPARE, 11'h7FF);  // must not restart the position
    add_word(pat[3]);
    add_word(pat[4]);
    add_word(pat[5]);
    add_tail(pat[0], pat[2], pat[4], pat[6], 1'b0);
    add_tail(pat[1], pat[3], pat[5], pat[7], 1'b1);
    // zero width and height clamp to one word, one band
    add_reg(REG_IMAGE_WIDTH, 11'd0);
    add_reg(REG_IMAGE_HEIGHT, 11'd0);
    add_word('0);
    add_word(ALL_ONES);
    add_word(64'h5555_5555_5555_5555);
    add_tail('0, ALL_ONES, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // next image follows the wrap
    add_word(pat[8]);
    add_word(pat[9]);
    add_word(pat[10]);
    add_word(pat[11]);
    // write mid-band restarts at row 0
    add_word(pat[0]);
    add_word(pat[1]);
    add_reg(REG_TEXEL_MODE, 11'h7FE);
    add_word(pat[2]);
    add_word(pat[3]);
    add_word(pat[4]);
    add_tail(pat[2], pat[3], pat[4], pat[5], 1'b1);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        cur_typed = (dir_tab[i].kind == ROW_TAIL);
        for (int k = 0; k < LAST_ROW; k++) begin
          typed_run[k].word      = dir_tab[i].held[k];
          typed_run[k].run_end   = 1'b0;
          typed_run[k].image_end = 1'b0;
        end
        typed_run[LAST_ROW].word      = dir_tab[i].word;
        typed_run[LAST_ROW].run_end   = 1'b1;
        typed_run[LAST_ROW].image_end = dir_tab[i].img_end;
        send_word(dir_tab[i].word);
      end
    end
    cur_typed = 1'b0;

    // small random images, whole and cut short by the next setting
    while (rand_words < RAND_WORDS || phase <= PAUSE_PHASE) begin
      write_reg(REG_TEXEL_MODE, CFG_DATA_W'($urandom_range(0, 2047)));
      write_reg(REG_IMAGE_WIDTH,
                CFG_DATA_W'(mode_q ? $urandom_range(0, 39) : $urandom_range(0, 19)));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      burst   = (phase == HOLD_PHASE);
      img     = row_words() * BAND_ROWS * band_count();
      n       = img * $urandom_range(1, 2);
      if ($urandom_range(0, 2) == 0) n += $urandom_range(1, img);
      if (phase == HOLD_PHASE) begin
        n       += 48;
        hold_req = 1'b1;  // fill the output queue until the input backs up
      end
      for (int i = 0; i < n; i++) begin
        if (phase == PAUSE_PHASE && i == n / 2) drain();
        send_word({$urandom, $urandom});
      end
      rand_words += n;
      phase++;
    end

    // widest and tallest settings: 2047 texels and rows saturate; start of image only
    no_idle = 1'b0;
    burst   = 1'b0;
    write_reg(REG_TEXEL_MODE, 11'd0);
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
    repeat (SAT_WORDS) send_word({$urandom, $urandom});

    drain();
    repeat (20) @(negedge clk_i);
    $display("%0d linear words in, %0d tiled words out, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("directed clamps and restarts, %0d small random images, saturated settings",
             phase);
    if (errors == 0 && tiled_q.size() == 0) begin
      $display("[linear_to_tiled_texture_unit] OK");
    end else begin
      $display("[linear_to_tiled_texture_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lttt_pkg.sv
hdl/lttt_ofifo.sv
hdl/linear_to_tiled_texture_unit.sv
hdl/lttt_check.sv
dv/tb_linear_to_tiled_texture_unit.sv
